// ----- hw/rtl/itf_pkg.sv -----
// Shared types and constants for the integer to text formatter.
// Used by itf_ctrl, itf_datapath and the top level; depends on nothing.
`default_nettype none

package itf_pkg;

    localparam logic [2:0] MODE_PTR  = 3'd0;
    localparam logic [2:0] MODE_SDEC = 3'd1;
    localparam logic [2:0] MODE_UDEC = 3'd2;
    localparam logic [2:0] MODE_LHEX = 3'd3;
    localparam logic [2:0] MODE_UHEX = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;

    localparam int          HEX32_DIGITS = 8;
    localparam int          DEC_DIGITS   = 10;
    localparam logic [31:0] RECIP_10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT  = 35;

    typedef struct packed {
        logic       load;
        logic       put;
        logic [7:0] put_char;
        logic       mul;
        logic       div;
        logic       emit;
    } itf_cmd_t;

    typedef struct packed {
        logic q_zero;
        logic skip;
        logic rem_last;
    } itf_sts_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < 4'd10)
            return CH_ZERO + {4'd0, d};
        else
            return base + {4'd0, d} - 8'd10;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/itf_datapath.sv -----
// Datapath: digit shift register, divide-by-ten by reciprocal multiply, output registers.
// Depends on itf_pkg; driven by itf_ctrl through itf_cmd_t.
`default_nettype none

module itf_datapath #(
    parameter int POINTER_HEX_DIGITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [2:0]        mode,
    input  wire logic [63:0]       number,
    input  wire itf_pkg::itf_cmd_t cmd,
    output itf_pkg::itf_sts_t      sts,
    output logic                   strobe,
    output logic [7:0]             character,
    output logic                   last_char,
    output logic [4:0]             total_length
);

    localparam int SLOTS = (POINTER_HEX_DIGITS > itf_pkg::DEC_DIGITS) ?
                           POINTER_HEX_DIGITS : itf_pkg::DEC_DIGITS;
    localparam int DIG_W = 4 * SLOTS;

    logic [DIG_W-1:0] dig_reg, dig_next;
    logic [4:0]       rem_reg, rem_next;
    logic [4:0]       len_reg, len_next;
    logic [31:0]      v_reg, v_next;
    logic [63:0]      prod_reg, prod_next;
    logic             hex_reg, hex_next;
    logic             upper_reg, upper_next;
    logic             strobe_reg, strobe_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic [4:0]       total_reg, total_next;

    logic [DIG_W-1:0] ptr_load, hex_load;
    logic [28:0]      quot;
    logic [31:0]      rem32;
    logic [31:0]      low, mag;
    logic [3:0]       top;

    assign low      = number[31:0];
    assign mag      = low[31] ? (~low + 32'd1) : low;
    assign ptr_load = DIG_W'(number[4*POINTER_HEX_DIGITS-1:0])
                      << (4 * (SLOTS - POINTER_HEX_DIGITS));
    assign hex_load = DIG_W'(low) << (4 * (SLOTS - itf_pkg::HEX32_DIGITS));
    assign quot     = prod_reg[63:itf_pkg::RECIP_SHIFT];
    assign rem32    = v_reg - ({quot, 3'b000} + {2'b00, quot, 1'b0});
    assign top      = dig_reg[DIG_W-1:DIG_W-4];

    assign sts = '{
        q_zero:   (quot == 29'd0),
        skip:     hex_reg && (top == 4'd0) && (rem_reg != 5'd1),
        rem_last: (rem_reg == 5'd1)
    };

    always_comb
    begin
        dig_next    = dig_reg;
        rem_next    = rem_reg;
        len_next    = len_reg;
        v_next      = v_reg;
        prod_next   = prod_reg;
        hex_next    = hex_reg;
        upper_next  = upper_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = 1'b0;
        total_next  = 5'd0;

        if (cmd.load)
        begin
            len_next   = 5'd0;
            rem_next   = 5'd0;
            hex_next   = 1'b0;
            upper_next = 1'b0;
            unique case (mode) inside
                itf_pkg::MODE_PTR:
                begin
                    dig_next = ptr_load;
                    rem_next = 5'(POINTER_HEX_DIGITS);
                    hex_next = 1'b1;
                end
                itf_pkg::MODE_SDEC: v_next = mag;
                itf_pkg::MODE_UDEC: v_next = low;
                itf_pkg::MODE_LHEX, itf_pkg::MODE_UHEX:
                begin
                    dig_next   = hex_load;
                    rem_next   = 5'(itf_pkg::HEX32_DIGITS);
                    hex_next   = 1'b1;
                    upper_next = (mode == itf_pkg::MODE_UHEX);
                end
                default: ;
            endcase
        end

        if (cmd.put)
        begin
            strobe_next = 1'b1;
            char_next   = cmd.put_char;
            len_next    = len_reg + 5'd1;
        end

        if (cmd.mul)
            prod_next = 64'(v_reg) * 64'(itf_pkg::RECIP_10);

        if (cmd.div)
        begin
            dig_next = {rem32[3:0], dig_reg[DIG_W-1:4]};
            v_next   = 32'(quot);
            rem_next = rem_reg + 5'd1;
        end

        if (cmd.emit)
        begin
            dig_next = {dig_reg[DIG_W-5:0], 4'd0};
            rem_next = rem_reg - 5'd1;
            if (!sts.skip)
            begin
                hex_next    = 1'b0;
                strobe_next = 1'b1;
                char_next   = itf_pkg::digit_char(top, upper_reg);
                len_next    = len_reg + 5'd1;
                last_next   = sts.rem_last;
                total_next  = sts.rem_last ? (len_reg + 5'd1) : 5'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            total_reg  <= 5'd0;
            rem_reg    <= 5'd0;
            len_reg    <= 5'd0;
            hex_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
            total_reg  <= total_next;
            rem_reg    <= rem_next;
            len_reg    <= len_next;
            hex_reg    <= hex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg   <= dig_next;
        v_reg     <= v_next;
        prod_reg  <= prod_next;
        upper_reg <= upper_next;
        char_reg  <= char_next;
    end

    assign strobe       = strobe_reg;
    assign character    = char_reg;
    assign last_char    = last_reg;
    assign total_length = total_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/itf_ctrl.sv -----
// Controller: sequences prefix, divide-by-ten loop and digit emission.
// Depends on itf_pkg; commands itf_datapath through itf_cmd_t.
`default_nettype none

module itf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2:0]        mode,
    input  wire logic              sign,
    input  wire itf_pkg::itf_sts_t sts,
    output itf_pkg::itf_cmd_t      cmd,
    output logic                   busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZERO,
        S_X,
        S_MINUS,
        S_MUL,
        S_DIV,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (mode) inside
                        itf_pkg::MODE_PTR:  state_next = S_ZERO;
                        itf_pkg::MODE_SDEC: state_next = sign ? S_MINUS : S_MUL;
                        itf_pkg::MODE_UDEC: state_next = S_MUL;
                        itf_pkg::MODE_LHEX, itf_pkg::MODE_UHEX: state_next = S_EMIT;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_ZERO:
            begin
                cmd.put      = 1'b1;
                cmd.put_char = itf_pkg::CH_ZERO;
                state_next   = S_X;
            end
            S_X:
            begin
                cmd.put      = 1'b1;
                cmd.put_char = itf_pkg::CH_X;
                state_next   = S_EMIT;
            end
            S_MINUS:
            begin
                cmd.put      = 1'b1;
                cmd.put_char = itf_pkg::CH_MINUS;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = sts.q_zero ? S_EMIT : S_MUL;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (!sts.skip && sts.rem_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/integer_to_text_formatter.sv -----
// Top level of the integer to text formatter: controller plus datapath.
// Depends on itf_pkg, itf_ctrl and itf_datapath.
//
//  channel   ports                                   transfer
//  request   start, mode, number                     start && !busy
//  result    strobe, character, last_char,           strobe, one cycle each
//            total_length
//
// One request at a time. Hex modes: a load step, then one step per nibble
// (8, or POINTER_HEX_DIGITS after the 0x prefix in pointer mode); leading
// zero nibbles take a step without a result. Decimal modes: a multiply and
// a divide step per digit through the reciprocal multiplier, then one emit
// step per character. Reset is asynchronous and returns to idle.
// The receiver cannot stall; modes 5 to 7 are dropped without results.
`default_nettype none

module integer_to_text_formatter #(
    parameter int POINTER_HEX_DIGITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  mode,
    input  wire logic [63:0] number,
    output logic             strobe,
    output logic [7:0]       character,
    output logic             last_char,
    output logic [4:0]       total_length
);

    itf_pkg::itf_cmd_t cmd;
    itf_pkg::itf_sts_t sts;
    logic              ctl_busy;

    itf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !ctl_busy),
        .mode  (mode),
        .sign  (number[31]),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (ctl_busy)
    );

    itf_datapath #(
        .POINTER_HEX_DIGITS (POINTER_HEX_DIGITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode),
        .number       (number),
        .cmd          (cmd),
        .sts          (sts),
        .strobe       (strobe),
        .character    (character),
        .last_char    (last_char),
        .total_length (total_length)
    );

    assign busy = ctl_busy;

endmodule

`default_nettype wire

// ----- hw/rtl/integer_to_text_formatter_chk.sv -----
// Port-level checker for integer_to_text_formatter, bound to the top level.
// Depends on the top level's ports and on itf_pkg.
`default_nettype none

module integer_to_text_formatter_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [2:0]  mode,
    input wire logic        strobe,
    input wire logic        last_char,
    input wire logic [4:0]  total_length
);

    a_last_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_char |-> strobe)
        else $error("last_char without strobe");

    a_length_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_char) |-> (total_length != 5'd0))
        else $error("zero total_length on last character");

    a_length_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        !last_char |-> (total_length == 5'd0))
        else $error("total_length set before last character");

    a_valid_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode <= itf_pkg::MODE_UHEX)) |=> busy)
        else $error("valid request did not raise busy");

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && last_char))
        else $error("busy dropped without a last character");

endmodule

bind integer_to_text_formatter integer_to_text_formatter_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .strobe       (strobe),
    .last_char    (last_char),
    .total_length (total_length)
);

`default_nettype wire
